// File: design/tcoq_pkg.sv
// Shared types and constants for the three-class oldest-first queue.
package tcoq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 512;
  localparam int unsigned NCLASS          = 3;
  localparam int unsigned OP_W            = 3;
  localparam int unsigned CLASS_W         = 2;
  localparam int unsigned KIND_W          = 4;
  localparam int unsigned PAYLOAD_BITS    = 32;
  localparam int unsigned ENTRY_W         = KIND_W + PAYLOAD_BITS;
  localparam int unsigned ORDER_W         = 48;
  localparam int unsigned CNT_W           = 48;
  localparam int unsigned FILL_OUT_W      = 10;
  localparam int unsigned PEAK_OUT_W      = 11;
  localparam int unsigned WORD_W          = ENTRY_W + ORDER_W;

  localparam logic [OP_W-1:0] OP_PUSH         = 3'd0;
  localparam logic [OP_W-1:0] OP_POP_CLASS    = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_OLDEST   = 3'd2;
  localparam logic [OP_W-1:0] OP_NOTE_APPLIED = 3'd3;
  localparam logic [OP_W-1:0] OP_NOTE_STALE   = 3'd4;
  localparam logic [OP_W-1:0] OP_RESET        = 3'd5;

  localparam logic [CLASS_W-1:0] CLASS_ANALYSIS    = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_SYMBOLS     = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_DIAGNOSTICS = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_NONE        = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_FETCH
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [CLASS_W-1:0]      queue_sel;
    logic [KIND_W-1:0]       entry_kind;
    logic [PAYLOAD_BITS-1:0] entry_data;
  } in_item_t;

  typedef struct packed {
    logic                  ok;
    logic [CLASS_W-1:0]    out_class;
    logic [ENTRY_W-1:0]    out_entry;
    logic [ORDER_W-1:0]    out_order;
    logic [FILL_OUT_W-1:0] analysis_fill;
    logic [FILL_OUT_W-1:0] symbols_fill;
    logic [FILL_OUT_W-1:0] diagnostics_fill;
    logic [PEAK_OUT_W-1:0] peak_fill;
    logic [CNT_W-1:0]      accepted_count;
    logic [CNT_W-1:0]      removed_count;
    logic [CNT_W-1:0]      applied_count;
    logic [CNT_W-1:0]      stale_count;
  } out_item_t;

endpackage

// File: design/tcoq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tcoq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/three_class_oldest_first_queue_unit.sv
// Three class FIFOs in one shared RAM, each with a head register, and oldest-first pop.
// Usage: an item is taken when start is high and busy is low; its result shows on out_item
// for exactly one cycle with out_valid, the cycle after the item finishes. Push, note and
// reset items finish in their accept cycle, so one can follow every cycle. A pop goes to
// ST_FETCH and finishes there once any empty heads it looks at (up to three for pop
// oldest) are refilled: all FIFO storage sits in one RAM with one read port and a
// registered read, so refills go one per cycle, then the last read returns and the head
// compare runs. The RAM is never cleared; fill counts guard every read.
module three_class_oldest_first_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = tcoq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tcoq_pkg::in_item_t  in_item,
  output logic                out_valid,
  output tcoq_pkg::out_item_t out_item
);

  import tcoq_pkg::*;

  localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MEM_DEPTH = NCLASS * QUEUE_DEPTH;
  localparam int unsigned ADDR_W = $clog2(MEM_DEPTH);
  localparam int unsigned PEAK_W = $clog2(NCLASS * QUEUE_DEPTH + 1);

  state_t                state_r, state_nxt;
  logic [PTR_W-1:0]      rptr_r [NCLASS];
  logic [PTR_W-1:0]      rptr_nxt [NCLASS];
  logic [PTR_W-1:0]      wptr_r [NCLASS];
  logic [PTR_W-1:0]      wptr_nxt [NCLASS];
  logic [FILL_W-1:0]     fill_r [NCLASS];
  logic [FILL_W-1:0]     fill_nxt [NCLASS];
  logic [NCLASS-1:0]     hv_r, hv_nxt;
  logic [ENTRY_W-1:0]    head_entry_r [NCLASS];
  logic [ENTRY_W-1:0]    head_entry_nxt [NCLASS];
  logic [ORDER_W-1:0]    head_order_r [NCLASS];
  logic [ORDER_W-1:0]    head_order_nxt [NCLASS];
  logic [ORDER_W-1:0]    next_order_r, next_order_nxt;
  logic [PEAK_W-1:0]     peak_r, peak_nxt;
  logic [CNT_W-1:0]      acc_cnt_r, acc_cnt_nxt;
  logic [CNT_W-1:0]      rem_cnt_r, rem_cnt_nxt;
  logic [CNT_W-1:0]      app_cnt_r, app_cnt_nxt;
  logic [CNT_W-1:0]      stale_cnt_r, stale_cnt_nxt;
  logic [NCLASS-1:0]     cand_r, cand_nxt;
  logic [NCLASS-1:0]     need_r, need_nxt;
  logic                  pend_r, pend_nxt;
  logic [CLASS_W-1:0]    pend_cls_r, pend_cls_nxt;
  logic                  out_valid_r;
  out_item_t             out_item_r;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [WORD_W-1:0]     ram_rdata;

  logic                  resp;
  logic                  r_ok;
  logic [CLASS_W-1:0]    r_cls;
  logic [ENTRY_W-1:0]    r_entry;
  logic [ORDER_W-1:0]    r_order;

  function automatic logic [ADDR_W-1:0] slot_addr(logic [CLASS_W-1:0] cls,
                                                  logic [PTR_W-1:0] ptr);
    logic [ADDR_W-1:0] base;
    case (cls)
      CLASS_SYMBOLS:     base = ADDR_W'(QUEUE_DEPTH);
      CLASS_DIAGNOSTICS: base = ADDR_W'(2 * QUEUE_DEPTH);
      default:           base = '0;
    endcase
    return base + ADDR_W'(ptr);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_step(logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  tcoq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    logic [CLASS_W-1:0] sel;
    logic [CLASS_W-1:0] fcls;
    logic [CLASS_W-1:0] pick;
    logic               found;
    logic [PEAK_W-1:0]  sum;
    logic [NCLASS-1:0]  nonempty;
    logic [NCLASS-1:0]  cand;

    state_nxt      = state_r;
    rptr_nxt       = rptr_r;
    wptr_nxt       = wptr_r;
    fill_nxt       = fill_r;
    hv_nxt         = hv_r;
    head_entry_nxt = head_entry_r;
    head_order_nxt = head_order_r;
    next_order_nxt = next_order_r;
    peak_nxt       = peak_r;
    acc_cnt_nxt    = acc_cnt_r;
    rem_cnt_nxt    = rem_cnt_r;
    app_cnt_nxt    = app_cnt_r;
    stale_cnt_nxt  = stale_cnt_r;
    cand_nxt       = cand_r;
    need_nxt       = need_r;
    pend_nxt       = pend_r;
    pend_cls_nxt   = pend_cls_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = '0;
    resp           = 1'b0;
    r_ok           = 1'b0;
    r_cls          = CLASS_ANALYSIS;
    r_entry        = '0;
    r_order        = '0;
    sel            = in_item.queue_sel;
    fcls           = CLASS_ANALYSIS;
    pick           = CLASS_ANALYSIS;
    found          = 1'b0;
    sum            = '0;
    cand           = '0;
    for (int c = 0; c < NCLASS; c++) begin
      nonempty[c] = (fill_r[c] != '0);
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_item.op)
            OP_PUSH: begin
              resp = 1'b1;
              if (in_item.entry_kind != '0 && sel != CLASS_NONE) begin
                // The sequence number is spent even when the FIFO is full.
                next_order_nxt = next_order_r + ORDER_W'(1);
                if (fill_r[sel] != FILL_W'(QUEUE_DEPTH)) begin
                  ram_we         = 1'b1;
                  ram_waddr      = slot_addr(sel, wptr_r[sel]);
                  ram_wdata      = {in_item.entry_kind, in_item.entry_data, next_order_r};
                  wptr_nxt[sel]  = ptr_step(wptr_r[sel]);
                  fill_nxt[sel]  = fill_r[sel] + FILL_W'(1);
                  acc_cnt_nxt    = acc_cnt_r + CNT_W'(1);
                  r_ok           = 1'b1;
                  sum = PEAK_W'(fill_nxt[0]) + PEAK_W'(fill_nxt[1]) + PEAK_W'(fill_nxt[2]);
                  if (sum > peak_r) begin
                    peak_nxt = sum;
                  end
                end
              end
            end
            OP_POP_CLASS, OP_POP_OLDEST: begin
              if (in_item.op == OP_POP_OLDEST) begin
                cand = '1;
              end else if (sel != CLASS_NONE) begin
                cand = NCLASS'(1) << sel;
              end
              cand_nxt  = cand;
              need_nxt  = cand & ~hv_r & nonempty;
              pend_nxt  = 1'b0;
              state_nxt = ST_FETCH;
            end
            OP_NOTE_APPLIED: begin
              resp        = 1'b1;
              r_ok        = 1'b1;
              app_cnt_nxt = app_cnt_r + CNT_W'(1);
            end
            OP_NOTE_STALE: begin
              resp          = 1'b1;
              r_ok          = 1'b1;
              stale_cnt_nxt = stale_cnt_r + CNT_W'(1);
            end
            OP_RESET: begin
              resp = 1'b1;
              r_ok = 1'b1;
              for (int c = 0; c < NCLASS; c++) begin
                rptr_nxt[c] = '0;
                wptr_nxt[c] = '0;
                fill_nxt[c] = '0;
              end
              hv_nxt         = '0;
              next_order_nxt = ORDER_W'(1);
              peak_nxt       = '0;
              acc_cnt_nxt    = '0;
              rem_cnt_nxt    = '0;
              app_cnt_nxt    = '0;
              stale_cnt_nxt  = '0;
            end
            default: begin
              resp = 1'b1;
            end
          endcase
        end
      end

      ST_FETCH: begin
        pend_nxt = 1'b0;
        if (pend_r) begin
          {head_entry_nxt[pend_cls_r], head_order_nxt[pend_cls_r]} = ram_rdata;
          hv_nxt[pend_cls_r] = 1'b1;
        end
        if (need_r != '0) begin
          // Refill the lowest class still waiting; one RAM read per cycle.
          if (need_r[0]) begin
            fcls = CLASS_ANALYSIS;
          end else if (need_r[1]) begin
            fcls = CLASS_SYMBOLS;
          end else begin
            fcls = CLASS_DIAGNOSTICS;
          end
          ram_raddr      = slot_addr(fcls, rptr_r[fcls]);
          rptr_nxt[fcls] = ptr_step(rptr_r[fcls]);
          fill_nxt[fcls] = fill_r[fcls] - FILL_W'(1);
          need_nxt[fcls] = 1'b0;
          pend_nxt       = 1'b1;
          pend_cls_nxt   = fcls;
        end else if (!pend_r) begin
          // Oldest valid candidate head; ties go to the lower class.
          for (int c = 0; c < NCLASS; c++) begin
            if (cand_r[c] && hv_r[c] &&
                (!found || head_order_r[c] < head_order_r[pick])) begin
              found = 1'b1;
              pick  = CLASS_W'(c);
            end
          end
          resp      = 1'b1;
          state_nxt = ST_IDLE;
          if (found) begin
            r_ok         = 1'b1;
            r_cls        = pick;
            r_entry      = head_entry_r[pick];
            r_order      = head_order_r[pick];
            hv_nxt[pick] = 1'b0;
            rem_cnt_nxt  = rem_cnt_r + CNT_W'(1);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      for (int c = 0; c < NCLASS; c++) begin
        rptr_r[c] <= '0;
        wptr_r[c] <= '0;
        fill_r[c] <= '0;
      end
      hv_r         <= '0;
      next_order_r <= ORDER_W'(1);
      peak_r       <= '0;
      acc_cnt_r    <= '0;
      rem_cnt_r    <= '0;
      app_cnt_r    <= '0;
      stale_cnt_r  <= '0;
      cand_r       <= '0;
      need_r       <= '0;
      pend_r       <= 1'b0;
      pend_cls_r   <= CLASS_ANALYSIS;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rptr_r       <= rptr_nxt;
      wptr_r       <= wptr_nxt;
      fill_r       <= fill_nxt;
      hv_r         <= hv_nxt;
      next_order_r <= next_order_nxt;
      peak_r       <= peak_nxt;
      acc_cnt_r    <= acc_cnt_nxt;
      rem_cnt_r    <= rem_cnt_nxt;
      app_cnt_r    <= app_cnt_nxt;
      stale_cnt_r  <= stale_cnt_nxt;
      cand_r       <= cand_nxt;
      need_r       <= need_nxt;
      pend_r       <= pend_nxt;
      pend_cls_r   <= pend_cls_nxt;
      out_valid_r  <= resp;
    end
  end

  // Head payload and result payload carry no reset.
  always_ff @(posedge clk) begin
    head_entry_r <= head_entry_nxt;
    head_order_r <= head_order_nxt;
    if (resp) begin
      out_item_r.ok               <= r_ok;
      out_item_r.out_class        <= r_cls;
      out_item_r.out_entry        <= r_entry;
      out_item_r.out_order        <= r_order;
      out_item_r.analysis_fill    <= FILL_OUT_W'(fill_nxt[0]);
      out_item_r.symbols_fill     <= FILL_OUT_W'(fill_nxt[1]);
      out_item_r.diagnostics_fill <= FILL_OUT_W'(fill_nxt[2]);
      out_item_r.peak_fill        <= PEAK_OUT_W'(peak_nxt);
      out_item_r.accepted_count   <= acc_cnt_nxt;
      out_item_r.removed_count    <= rem_cnt_nxt;
      out_item_r.applied_count    <= app_cnt_nxt;
      out_item_r.stale_count      <= stale_cnt_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_idle_no_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!pend_r && need_r == '0))
    else $error("refill work left over while idle");

  a_need_in_cand: assert property (@(posedge clk) disable iff (!rst_n)
    (need_r & ~cand_r) == '0)
    else $error("refill requested outside pop candidates");

  a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_IDLE && start))
    else $error("storage write outside an accepted push");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r[0] <= FILL_W'(QUEUE_DEPTH)) && (fill_r[1] <= FILL_W'(QUEUE_DEPTH)) &&
    (fill_r[2] <= FILL_W'(QUEUE_DEPTH)))
    else $error("FIFO fill above depth");

  a_pop_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH && state_nxt == ST_IDLE) |=> (out_valid && !busy))
    else $error("pop finished without a result");

endmodule
